// ===== sv/grid_neighbor_cell_enumerator_defines.svh =====
// Assertion macros shared by the grid neighbor cell enumerator modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef GRID_NEIGHBOR_CELL_ENUMERATOR_DEFINES_SVH
`define GRID_NEIGHBOR_CELL_ENUMERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GNCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GNCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gnce_pkg.sv =====
// Shared types and constants of the grid neighbor cell enumerator.
// Depends on nothing; imported by every module of the block.
package gnce_pkg;

    localparam int DATA_W       = 64;
    localparam int DELTA_W      = 62;
    localparam int NUM_LANES    = 3;
    localparam int DEF_MAX_DIMS = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DIV_STEPS    = DATA_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int PADDR_W      = 5;

    localparam logic [1:0] REG_DELTA = 2'd0;
    localparam logic [1:0] REG_WIDE  = 2'd1;
    localparam logic [1:0] REG_DIMS  = 2'd2;

    localparam logic [DELTA_W-1:0] DELTA_RST = DELTA_W'(1);
    localparam logic [1:0]         DIMS_RST  = 2'd2;

    // One point after division: corner per lane and the mode it was taken in.
    typedef struct packed {
        logic [NUM_LANES-1:0][DATA_W-1:0] corner;
        logic                             wide;
        logic [1:0]                       nd;
    } t_job;

endpackage

// ===== sv/grid_neighbor_cell_enumerator.sv =====
// Grid neighbor cell enumerator: top level, configuration registers and wiring.
// Depends on gnce_pkg, gnce_front, gnce_fifo and gnce_back.
//
// Usage. Points enter on a queue-style port: an item is taken at a rising edge
// with push high and full low, carrying i_coord_0 to i_coord_2. Results leave
// on a queue-style port: while empty is low the oldest cell is on o_cell_0 to
// o_cell_2 and o_last, and it is taken at an edge with pop high.
// Each point yields 2^dims cells in wide mode or 3^dims cells in fine mode,
// lane 0 varying fastest, and o_last marks the final cell of the point.
// The front end divides all lanes in parallel with a restoring divider that
// retires one quotient bit per cycle, and it takes no new point until the
// divided one is handed to the queue. The back end emits one cell per cycle
// while results are taken and a point waits in the queue.
// Front and back run independently through a two-entry queue, so the front
// end can divide the next point while the back end emits cells of earlier
// ones. When the receiver stalls, the result register holds its cell, the
// queue fills, and then full rises; nothing is dropped.
// Configuration is written over APB at byte address 8*i (delta, wide_mode,
// dims); the user must write it only while the block is idle (not enforced).
// Reset clears all control state, loads delta = 1, fine mode and two dims.
module grid_neighbor_cell_enumerator
    import gnce_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // Point input.
    input  logic               push,
    output logic               full,
    input  logic [DATA_W-1:0]  i_coord_0,
    input  logic [DATA_W-1:0]  i_coord_1,
    input  logic [DATA_W-1:0]  i_coord_2,
    // Cell output.
    output logic               empty,
    input  logic               pop,
    output logic [DATA_W-1:0]  o_cell_0,
    output logic [DATA_W-1:0]  o_cell_1,
    output logic [DATA_W-1:0]  o_cell_2,
    output logic               o_last
);

    logic [DELTA_W-1:0] r_delta;
    logic               r_wide_mode;
    logic [1:0]         r_dims;
    logic [1:0]         w_reg_idx;
    logic               w_wr;

    logic               w_q_push;
    logic               w_q_full;
    logic               w_q_pop;
    logic               w_q_valid;
    t_job               w_job_in;
    t_job               w_job_out;

    // Register index is the address divided by eight; byte lanes are ignored.
    assign w_reg_idx = paddr[4:3];
    assign pready    = 1'b1;
    assign w_wr      = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta     <= DELTA_RST;
            r_wide_mode <= 1'b0;
            r_dims      <= DIMS_RST;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_DELTA: r_delta     <= pwdata[DELTA_W-1:0];
                REG_WIDE:  r_wide_mode <= pwdata[0];
                REG_DIMS:  r_dims      <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_DELTA: prdata = {{(DATA_W-DELTA_W){1'b0}}, r_delta};
            REG_WIDE:  prdata = {{(DATA_W-1){1'b0}}, r_wide_mode};
            REG_DIMS:  prdata = {{(DATA_W-2){1'b0}}, r_dims};
            default:   prdata = '0;
        endcase
    end

    gnce_front #(
        .MAX_DIMS (MAX_DIMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_coord_0   (i_coord_0),
        .i_coord_1   (i_coord_1),
        .i_coord_2   (i_coord_2),
        .i_delta     (r_delta),
        .i_wide_mode (r_wide_mode),
        .i_dims      (r_dims),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_job       (w_job_in)
    );

    gnce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_job_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_job_out)
    );

    gnce_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_job_out),
        .o_q_pop   (w_q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_cell_0  (o_cell_0),
        .o_cell_1  (o_cell_1),
        .o_cell_2  (o_cell_2),
        .o_last    (o_last)
    );

endmodule

// ===== sv/gnce_div.sv =====
// One lane of the corner divider: restoring division, one quotient bit per step.
// Depends on gnce_pkg for the data width.
module gnce_div
    import gnce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_start,
    input  logic              i_step,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic [DATA_W-1:0] o_quo
);

    logic [DATA_W-1:0] r_num;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;
    logic              w_ge;

    // The dividend shifts out at the top while quotient bits shift in below.
    // A zero divisor makes every step succeed, so the quotient ends all ones.
    assign w_trial = {r_rem, r_num[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_num <= {r_num[DATA_W-2:0], w_ge};
        end
    end

    assign o_quo = r_num;

endmodule

// ===== sv/gnce_front.sv =====
// Front end: accepts a point, snapshots the mode and divides each lane below MAX_DIMS.
// Depends on gnce_pkg, gnce_div and the assertion macro header.
`include "grid_neighbor_cell_enumerator_defines.svh"
module gnce_front
    import gnce_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [DATA_W-1:0]  i_coord_0,
    input  logic [DATA_W-1:0]  i_coord_1,
    input  logic [DATA_W-1:0]  i_coord_2,
    input  logic [DELTA_W-1:0] i_delta,
    input  logic               i_wide_mode,
    input  logic [1:0]         i_dims,
    input  logic               i_q_full,
    output logic               o_q_push,
    output t_job               o_job
);

    localparam logic [1:0]        MaxNd    = 2'(MAX_DIMS);
    localparam logic [STEP_W-1:0] LastStep = STEP_W'(DIV_STEPS - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_wide;
    logic [1:0]          r_nd;
    logic                w_accept;
    logic [DATA_W-1:0]   w_side;
    logic [DATA_W-1:0]   w_delta;
    logic [NUM_LANES-1:0][DATA_W-1:0] w_coord;
    logic [NUM_LANES-1:0][DATA_W-1:0] w_quo;

    // A new point may enter in the same cycle the finished one leaves.
    assign full     = r_busy | (r_done & i_q_full);
    assign w_accept = push & ~full;
    assign o_q_push = r_done & ~i_q_full;

    assign w_delta = {2'b00, i_delta};
    assign w_side  = i_wide_mode ? {i_delta, 2'b00} : w_delta;
    assign w_coord = {i_coord_2, i_coord_1, i_coord_0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (o_q_push) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wide <= i_wide_mode;
            r_nd   <= (i_dims > MaxNd) ? MaxNd : i_dims;
        end
    end

    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        if (j < MAX_DIMS) begin : g_div
            gnce_div u_div (
                .i_clk   (i_clk),
                .i_start (w_accept),
                .i_step  (r_busy),
                .i_num   (w_coord[j] - w_delta),
                .i_den   (w_side),
                .o_quo   (w_quo[j])
            );
        end else begin : g_none
            assign w_quo[j] = '0;
        end
    end

    assign o_job.corner = w_quo;
    assign o_job.wide   = r_wide;
    assign o_job.nd     = r_nd;

    `GNCE_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept,
        r_busy && (r_cnt == '0), "accepted point did not start the divider")
    `GNCE_ASSERT_IMPL(a_busy_done_excl, i_clk, i_rst_n, r_done, !r_busy,
        "divider busy and done at once")
    `GNCE_ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n,
        r_busy && (r_cnt == LastStep) && !w_accept, r_done && !r_busy,
        "divider did not finish after its last step")

endmodule

// ===== sv/gnce_fifo.sv =====
// Short queue of divided points between the front end and the cell sequencer.
// Depends on gnce_pkg for the job type and depth.
module gnce_fifo
    import gnce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd_ptr];

endmodule

// ===== sv/gnce_back.sv =====
// Back end: walks the neighbor offsets of the head point and drives the
// result register. Depends on gnce_pkg and the assertion macro header.
`include "grid_neighbor_cell_enumerator_defines.svh"
module gnce_back
    import gnce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_job              i_job,
    output logic              o_q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [DATA_W-1:0] o_cell_0,
    output logic [DATA_W-1:0] o_cell_1,
    output logic [DATA_W-1:0] o_cell_2,
    output logic              o_last
);

    logic [NUM_LANES-1:0][1:0]        r_d;
    logic [NUM_LANES-1:0][1:0]        n_d;
    logic                             r_out_valid;
    logic [NUM_LANES-1:0][DATA_W-1:0] r_cell;
    logic                             r_last;
    logic [NUM_LANES-1:0][DATA_W-1:0] w_cell;
    logic [1:0]                       w_dmax;
    logic                             w_last;
    logic                             w_load;
    logic                             w_carry;

    assign w_dmax = i_job.wide ? 2'd1 : 2'd2;
    assign w_load = i_q_valid & (~r_out_valid | pop);
    assign o_q_pop = w_load & w_last;

    // Digits advance as a base-2 (wide) or base-3 (fine) counter over the used lanes, lane 0 lowest.
    always_comb begin
        w_last  = 1'b1;
        w_carry = 1'b1;
        n_d     = r_d;
        for (int j = 0; j < NUM_LANES; j++) begin
            w_cell[j] = '0;
            if (2'(j) < i_job.nd) begin
                w_cell[j] = i_job.corner[j] + {{(DATA_W-2){1'b0}}, r_d[j]};
                if (r_d[j] != w_dmax) begin
                    w_last = 1'b0;
                end
                if (w_carry) begin
                    if (r_d[j] == w_dmax) begin
                        n_d[j] = 2'd0;
                    end else begin
                        n_d[j]  = r_d[j] + 2'd1;
                        w_carry = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_d         <= w_last ? '0 : n_d;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cell <= w_cell;
            r_last <= w_last;
        end
    end

    assign empty    = ~r_out_valid;
    assign o_cell_0 = r_cell[0];
    assign o_cell_1 = r_cell[1];
    assign o_cell_2 = r_cell[2];
    assign o_last   = r_last;

    `GNCE_ASSERT_NEXT(a_pop_clears_digits, i_clk, i_rst_n, o_q_pop,
        (r_d == '0) && r_last && r_out_valid, "point retired without clean restart")
    `GNCE_ASSERT_IMPL(a_digit_range, i_clk, i_rst_n, i_q_valid,
        (r_d[0] <= w_dmax) && (r_d[1] <= w_dmax) && (r_d[2] <= w_dmax),
        "offset digit beyond the radix")
    `GNCE_ASSERT_IMPL(a_idle_digits_zero, i_clk, i_rst_n, !i_q_valid, r_d == '0,
        "offset digits left over with no point waiting")

endmodule
